// ===== rtl/core/mwpa_pkg.sv =====
// Shared types and constants of the mecanum wheel power allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mwpa_pkg;

    localparam int WHEEL_COUNT = 4;

    localparam int SPEED_W   = 24;
    localparam int LIMIT_W   = 15;
    localparam int SUM_W     = 26;
    localparam int SHARE_W   = 26;
    localparam int DEN_W     = 25;
    localparam int MB_W      = 34;
    localparam int LQ_W      = 16;

    localparam logic [45:0] ROUND_HALF = 46'd128000;
    localparam logic [45:0] SAT_POS    = 46'd2147483648000;
    localparam logic [45:0] SAT_NEG    = 46'd2147483904000;
    localparam logic [30:0] RECIP_125  = 31'd1099511628;
    localparam logic [28:0] LIMIT_NUM  = 29'd468228096;
    localparam logic [9:0]  LIMIT_DEN  = 10'd935;
    localparam logic [6:0]  ZERO_RPM_SCALE = 7'd100;

    typedef enum logic [1:0] {
        CFG_POWER      = 2'd0,
        CFG_HALF_FRAME = 2'd1,
        CFG_INV_RADIUS = 2'd2,
        CFG_CLAMP      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                      sum_zero;
        logic                      rpm_zero;
        logic [DEN_W-1:0]          den;
        logic signed [SPEED_W-1:0] speed;
    } t_lane_side;

    typedef struct packed {
        logic                      ovf;
        logic signed [SPEED_W-1:0] speed;
    } t_lim_side;

endpackage
`default_nettype wire

// ===== rtl/core/mwpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// The upper dividend part must be below the divisor; uses mwpa_pkg only for style.
`default_nettype none
module mwpa_div
    import mwpa_pkg::*;
#(
    parameter int QW = 16,
    parameter int VW = 25,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [VW-1:0] i_rem,
    input  wire logic [QW-1:0] i_low,
    input  wire logic [VW-1:0] i_div,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [VW-1:0] r_rem  [QW];
    logic [VW-1:0] r_div  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [VW-1:0] s_rem;
        logic [VW-1:0] s_div;
        logic [QW-1:0] s_low;
        logic [QW-1:0] s_quo;
        logic [SW-1:0] s_side;
        logic          s_vld;
        logic [VW:0]   w_trial;
        logic          w_ge;
        logic [VW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_rem  = i_rem;
            assign s_div  = i_div;
            assign s_low  = i_low;
            assign s_quo  = '0;
            assign s_side = i_side;
            assign s_vld  = i_vld;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_div  = r_div[k-1];
            assign s_low  = r_low[k-1];
            assign s_quo  = r_quo[k-1];
            assign s_side = r_side[k-1];
            assign s_vld  = r_vld[k-1];
        end

        assign w_trial = {s_rem, s_low[QW-1]};
        assign w_ge    = w_trial >= {1'b0, s_div};
        assign n_rem   = w_ge ? VW'(w_trial - {1'b0, s_div}) : w_trial[VW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_div[k]  <= s_div;
                r_low[k]  <= {s_low[QW-2:0], 1'b0};
                r_quo[k]  <= {s_quo[QW-2:0], w_ge};
                r_side[k] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

// ===== rtl/core/mwpa_speed.sv =====
// Wheel speed front end: kinematics, scaling, rounding, saturation and speed sum.
// Seven register stages; depends on mwpa_pkg.
`default_nettype none
module mwpa_speed
    import mwpa_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic signed [15:0]       i_vel_x,
    input  wire logic signed [15:0]       i_vel_y,
    input  wire logic signed [15:0]       i_yaw_rate,
    input  wire logic signed [15:0]       i_rpm [WHEEL_COUNT],
    input  wire logic [9:0]               i_budget,
    input  wire logic [10:0]              i_half_frame,
    input  wire logic [15:0]              i_inv_radius,
    output logic                          o_vld,
    output logic [SUM_W-1:0]              o_sum,
    output logic [MB_W-1:0]               o_mb [WHEEL_COUNT],
    output t_lane_side                    o_side [WHEEL_COUNT]
);

    localparam int CARRY = 6;

    logic [6:0] r_vld;

    logic signed [26:0] r1_vx, r1_vy;
    logic signed [27:0] r1_rot;
    logic [DEN_W-1:0]   r_den [CARRY][WHEEL_COUNT];
    logic               r_rz  [CARRY][WHEEL_COUNT];

    logic [28:0]        r2_mag [WHEEL_COUNT];
    logic               r2_neg [WHEEL_COUNT];
    logic [44:0]        r3_prod [WHEEL_COUNT];
    logic               r3_neg [WHEEL_COUNT];
    logic [29:0]        r4_y [WHEEL_COUNT];
    logic               r4_neg [WHEEL_COUNT];
    logic               r4_sat [WHEEL_COUNT];
    logic [60:0]        r5_prod [WHEEL_COUNT];
    logic               r5_neg [WHEEL_COUNT];
    logic               r5_sat [WHEEL_COUNT];
    logic signed [SPEED_W-1:0] r6_spd [WHEEL_COUNT];
    logic [SPEED_W-1:0] r6_mag [WHEEL_COUNT];

    logic [SUM_W-1:0]   r7_sum;
    logic [MB_W-1:0]    r7_mb [WHEEL_COUNT];
    t_lane_side         r7_side [WHEEL_COUNT];

    logic [15:0]        n1_abs [WHEEL_COUNT];
    logic signed [29:0] n2_lin [WHEEL_COUNT];
    logic [45:0]        n4_t [WHEEL_COUNT];
    logic [SPEED_W-1:0] n6_q [WHEEL_COUNT];
    logic [SUM_W-1:0]   n7_sum;

    always_comb begin
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            n1_abs[i] = i_rpm[i][15] ? (~i_rpm[i] + 16'd1) : i_rpm[i];
        end
        n2_lin[0] = 30'(r1_vx) + 30'(r1_vy) + 30'(r1_rot);
        n2_lin[1] = 30'(r1_vx) - 30'(r1_vy) + 30'(r1_rot);
        n2_lin[2] = 30'(r1_rot) - 30'(r1_vx) - 30'(r1_vy);
        n2_lin[3] = 30'(r1_vy) - 30'(r1_vx) + 30'(r1_rot);
        n7_sum = '0;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
            n4_t[i] = 46'(r3_prod[i]) + ROUND_HALF;
            n6_q[i] = r5_prod[i][60:37];
            n7_sum  = n7_sum + SUM_W'(r6_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vx  <= 27'(i_vel_x) * 27'sd1000;
            r1_vy  <= 27'(i_vel_y) * 27'sd1000;
            r1_rot <= 28'(i_yaw_rate) * $signed({17'd0, i_half_frame});
            for (int i = 0; i < WHEEL_COUNT; i++) begin
                r_rz[0][i]  <= (n1_abs[i] == 16'd0);
                r_den[0][i] <= DEN_W'((n1_abs[i] == 16'd0) ? 16'd1 : n1_abs[i])
                               * DEN_W'(LIMIT_DEN);
                for (int s = 1; s < CARRY; s++) begin
                    r_rz[s][i]  <= r_rz[s-1][i];
                    r_den[s][i] <= r_den[s-1][i];
                end

                r2_neg[i] <= n2_lin[i][29];
                r2_mag[i] <= n2_lin[i][29] ? 29'(-n2_lin[i]) : n2_lin[i][28:0];

                r3_neg[i]  <= r2_neg[i];
                r3_prod[i] <= 45'(r2_mag[i]) * 45'(i_inv_radius);

                r4_neg[i] <= r3_neg[i];
                r4_sat[i] <= r3_neg[i] ? (n4_t[i] >= SAT_NEG) : (n4_t[i] >= SAT_POS);
                r4_y[i]   <= n4_t[i][40:11];

                r5_neg[i]  <= r4_neg[i];
                r5_sat[i]  <= r4_sat[i];
                r5_prod[i] <= 61'(r4_y[i]) * 61'(RECIP_125);

                if (r5_sat[i]) begin
                    r6_spd[i] <= r5_neg[i] ? 24'sh800000 : 24'sh7FFFFF;
                    r6_mag[i] <= r5_neg[i] ? 24'd8388608 : 24'd8388607;
                end else begin
                    r6_spd[i] <= r5_neg[i] ? $signed(-n6_q[i]) : $signed(n6_q[i]);
                    r6_mag[i] <= n6_q[i];
                end

                r7_mb[i]            <= MB_W'(r6_mag[i]) * MB_W'(i_budget);
                r7_side[i].sum_zero <= (n7_sum == '0);
                r7_side[i].rpm_zero <= r_rz[CARRY-1][i];
                r7_side[i].den      <= r_den[CARRY-1][i];
                r7_side[i].speed    <= r6_spd[i];
            end
            r7_sum <= n7_sum;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_sum  = r7_sum;
    assign o_mb   = r7_mb;
    assign o_side = r7_side;

endmodule
`default_nettype wire

// ===== rtl/core/mwpa_limit.sv =====
// Per-wheel current limit lane: power share to limit, divide by rpm, clamp.
// Depends on mwpa_pkg and mwpa_div.
`default_nettype none
module mwpa_limit
    import mwpa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [SHARE_W-1:0]     i_quo,
    input  wire t_lane_side             i_side,
    input  wire logic [9:0]             i_budget,
    input  wire logic [LIMIT_W-1:0]     i_clamp,
    output logic                        o_vld,
    output logic signed [SPEED_W-1:0]   o_speed,
    output logic [LIMIT_W-1:0]          o_limit
);

    logic [3:0]                r_vld;
    logic [54:0]               r1_a;
    logic                      r1_rz;
    logic [DEN_W-1:0]          r1_den, r2_den;
    logic signed [SPEED_W-1:0] r1_spd, r2_spd, r3_spd;
    logic [45:0]               r2_nn;
    logic                      r3_ovf;
    logic [DEN_W-1:0]          r3_rem, r3_den;
    logic [LQ_W-1:0]           r3_low;
    logic signed [SPEED_W-1:0] r4_spd;
    logic [LIMIT_W-1:0]        r4_lim;

    logic [SHARE_W-1:0]        n1_share;
    logic [61:0]               n2_num;
    logic [29:0]               n3_hi;
    logic                      n3_ovf;
    t_lim_side                 w_side_in, w_side_out;
    logic [$bits(t_lim_side)-1:0] w_side_vec;
    logic                      w_div_vld;
    logic [LQ_W-1:0]           w_quo;

    always_comb begin
        n1_share = i_side.sum_zero ? SHARE_W'({i_budget, 14'd0}) : i_quo;
        n2_num   = r1_rz ? 62'(r1_a) * 62'(ZERO_RPM_SCALE) : 62'(r1_a);
        n3_hi    = r2_nn[45:16];
        n3_ovf   = n3_hi >= 30'(r2_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {w_div_vld, r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= 55'(n1_share) * 55'(LIMIT_NUM);
            r1_rz  <= i_side.rpm_zero;
            r1_den <= i_side.den;
            r1_spd <= i_side.speed;

            r2_nn  <= n2_num[61:16];
            r2_den <= r1_den;
            r2_spd <= r1_spd;

            r3_ovf <= n3_ovf;
            r3_rem <= n3_ovf ? '0 : n3_hi[DEN_W-1:0];
            r3_low <= r2_nn[LQ_W-1:0];
            r3_den <= r2_den;
            r3_spd <= r2_spd;

            r4_spd <= w_side_out.speed;
            r4_lim <= (w_side_out.ovf || (w_quo > LQ_W'(i_clamp))) ? i_clamp
                                                                   : w_quo[LIMIT_W-1:0];
        end
    end

    assign w_side_in.ovf   = r3_ovf;
    assign w_side_in.speed = r3_spd;
    assign w_side_out      = w_side_vec;

    mwpa_div #(
        .QW (LQ_W),
        .VW (DEN_W),
        .SW ($bits(t_lim_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_vld[2]),
        .i_rem   (r3_rem),
        .i_low   (r3_low),
        .i_div   (r3_den),
        .i_side  (w_side_in),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_side_vec)
    );

    assign o_vld   = r_vld[3];
    assign o_speed = r4_spd;
    assign o_limit = r4_lim;

endmodule
`default_nettype wire

// ===== rtl/core/mecanum_wheel_power_allocator_core.sv =====
// Mecanum wheel power allocator: top level, configuration registers and lanes.
// Depends on mwpa_pkg, mwpa_speed, mwpa_div and mwpa_limit.
//
// Usage: a command item (vel_x, vel_y, yaw_rate and four wheel rpms) is taken
// when i_valid is high and o_stall is low. Each item gives one result item of
// four wheel speeds and four current limits, shown with o_valid and taken when
// i_stall is low. An item passes the speed front end, the share divider, the
// limit scaling, the rpm divider and the clamp, in that order; one item is
// accepted in every cycle while o_stall is low. When the receiver stalls a
// waiting result, the whole pipeline holds and o_stall rises, so nothing is
// lost or repeated. Configuration writes are always ready and take effect at
// once; the user must make them while the block is idle, not enforced by the
// block. Reset empties the pipeline and loads the default register values.
`default_nettype none
module mecanum_wheel_power_allocator_core
    import mwpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [15:0]    i_vel_x,
    input  wire logic signed [15:0]    i_vel_y,
    input  wire logic signed [15:0]    i_yaw_rate,
    input  wire logic signed [15:0]    i_rpm_front_left,
    input  wire logic signed [15:0]    i_rpm_front_right,
    input  wire logic signed [15:0]    i_rpm_rear_right,
    input  wire logic signed [15:0]    i_rpm_rear_left,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [23:0]         o_speed_front_left,
    output logic signed [23:0]         o_speed_front_right,
    output logic signed [23:0]         o_speed_rear_right,
    output logic signed [23:0]         o_speed_rear_left,
    output logic [14:0]                o_limit_front_left,
    output logic [14:0]                o_limit_front_right,
    output logic [14:0]                o_limit_rear_right,
    output logic [14:0]                o_limit_rear_left,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);

    logic [9:0]         r_budget;
    logic [10:0]        r_half_frame;
    logic [15:0]        r_inv_radius;
    logic [LIMIT_W-1:0] r_clamp;

    logic               w_en;
    logic signed [15:0] w_rpm [WHEEL_COUNT];
    logic               w_spd_vld;
    logic [SUM_W-1:0]   w_sum;
    logic [MB_W-1:0]    w_mb [WHEEL_COUNT];
    t_lane_side         w_side [WHEEL_COUNT];
    logic [WHEEL_COUNT-1:0] w_div_vld;
    logic [WHEEL_COUNT-1:0] w_lim_vld;
    logic signed [SPEED_W-1:0] w_speed [WHEEL_COUNT];
    logic [LIMIT_W-1:0] w_limit [WHEEL_COUNT];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget     <= 10'd80;
            r_half_frame <= 11'd400;
            r_inv_radius <= 16'd862;
            r_clamp      <= 15'd16384;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POWER:      r_budget     <= i_cfg_data[9:0];
                CFG_HALF_FRAME: r_half_frame <= i_cfg_data[10:0];
                CFG_INV_RADIUS: r_inv_radius <= i_cfg_data;
                CFG_CLAMP:      r_clamp      <= i_cfg_data[LIMIT_W-1:0];
                default:        r_budget     <= r_budget;
            endcase
        end
    end

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_rpm[0] = i_rpm_front_left;
    assign w_rpm[1] = i_rpm_front_right;
    assign w_rpm[2] = i_rpm_rear_right;
    assign w_rpm[3] = i_rpm_rear_left;

    mwpa_speed u_speed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (i_valid),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_yaw_rate   (i_yaw_rate),
        .i_rpm        (w_rpm),
        .i_budget     (r_budget),
        .i_half_frame (r_half_frame),
        .i_inv_radius (r_inv_radius),
        .o_vld        (w_spd_vld),
        .o_sum        (w_sum),
        .o_mb         (w_mb),
        .o_side       (w_side)
    );

    for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_lane
        logic [SHARE_W-1:0]            w_quo;
        logic [$bits(t_lane_side)-1:0] w_side_vec;
        t_lane_side                    w_side_out;

        mwpa_div #(
            .QW (SHARE_W),
            .VW (SUM_W),
            .SW ($bits(t_lane_side))
        ) u_share_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_spd_vld),
            .i_rem   (SUM_W'(w_mb[i][MB_W-1:10])),
            .i_low   ({w_mb[i][9:0], 16'd0}),
            .i_div   (w_sum),
            .i_side  (w_side[i]),
            .o_vld   (w_div_vld[i]),
            .o_quo   (w_quo),
            .o_side  (w_side_vec)
        );

        assign w_side_out = w_side_vec;

        mwpa_limit u_limit (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_vld    (w_div_vld[i]),
            .i_quo    (w_quo),
            .i_side   (w_side_out),
            .i_budget (r_budget),
            .i_clamp  (r_clamp),
            .o_vld    (w_lim_vld[i]),
            .o_speed  (w_speed[i]),
            .o_limit  (w_limit[i])
        );
    end

    assign o_valid             = w_lim_vld[0];
    assign o_speed_front_left  = w_speed[0];
    assign o_speed_front_right = w_speed[1];
    assign o_speed_rear_right  = w_speed[2];
    assign o_speed_rear_left   = w_speed[3];
    assign o_limit_front_left  = w_limit[0];
    assign o_limit_front_right = w_limit[1];
    assign o_limit_rear_right  = w_limit[2];
    assign o_limit_rear_left   = w_limit[3];

`ifndef SYNTHESIS
    a_div_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_vld == '0) || (w_div_vld == '1))
        else $error("share divider lanes out of step");

    a_limit_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lim_vld == '0) || (w_lim_vld == '1))
        else $error("limit lanes out of step");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench of the mecanum wheel power allocator: random and directed command
// items, checked against a predictor with its own register copy. Uses mwpa_pkg.
`default_nettype none
class alloc_scoreboard;
    typedef struct {
        logic signed [23:0] spd [4];
        logic [14:0]        lim [4];
    } t_wheel_result;

    t_wheel_result pending[$];
    longint unsigned budget, half_frame, inv_radius, clamp;
    int errors;

    function new();
        budget = 80; half_frame = 400; inv_radius = 862; clamp = 16384; errors = 0;
    endfunction

    function void write_reg(mwpa_pkg::t_cfg_idx idx, logic [15:0] data);
        case (idx)
            mwpa_pkg::CFG_POWER:      budget = data[9:0];
            mwpa_pkg::CFG_HALF_FRAME: half_frame = data[10:0];
            mwpa_pkg::CFG_INV_RADIUS: inv_radius = data;
            mwpa_pkg::CFG_CLAMP:      clamp = data[14:0];
            default: ;
        endcase
    endfunction

    function longint wheel_speed(longint um);
        longint unsigned m, q;
        m = (um < 0) ? -um : um;
        q = (m * inv_radius + 128000) / 256000;
        if (um < 0) return (q > 8388608) ? -8388608 : -longint'(q);
        return (q > 8388607) ? 8388607 : longint'(q);
    endfunction

    function void note_command(logic signed [15:0] vx, vy, wz, logic signed [15:0] rpm [4]);
        t_wheel_result r;
        longint lin [4];
        longint unsigned mag [4];
        longint unsigned sum, share, rmag, lim;
        logic [127:0] num, den;
        longint sv, rot, x, y;
        x = longint'(vx) * 1000; y = longint'(vy) * 1000;
        rot = longint'(wz) * longint'(half_frame);
        lin[0] = x + y + rot;
        lin[1] = -(-x + y - rot);
        lin[2] = -(x + y - rot);
        lin[3] = -x + y + rot;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            sv = wheel_speed(lin[i]);
            r.spd[i] = sv[23:0];
            mag[i] = (sv < 0) ? -sv : sv;
            sum += mag[i];
        end
        for (int i = 0; i < 4; i++) begin
            share = (sum == 0) ? budget * 16384 : (mag[i] * budget * 65536) / sum;
            rmag = (rpm[i] < 0) ? -longint'(rpm[i]) : longint'(rpm[i]);
            num = 128'(share) * 128'd468228096;
            if (rmag == 0) begin
                num = num * 100;
                rmag = 1;
            end
            den = 128'd935 * 128'd65536 * 128'(rmag);
            lim = (num / den > 128'(clamp)) ? clamp : longint'(num / den);
            r.lim[i] = lim[14:0];
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [23:0] spd [4], logic [14:0] lim [4]);
        t_wheel_result e;
        if (pending.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (spd[i] !== e.spd[i]) begin
                $display("%0t: speed %0d expected %0d actual %0d", $time, i, e.spd[i], spd[i]);
                errors++;
            end
            if (lim[i] !== e.lim[i]) begin
                $display("%0t: limit %0d expected %0d actual %0d", $time, i, e.lim[i], lim[i]);
                errors++;
            end
        end
    endfunction
endclass

module tb_top
    import mwpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n, in_valid, out_stall, out_valid, in_stall, cfg_valid, cfg_ready;
    logic signed [15:0] vel_x, vel_y, yaw;
    logic signed [15:0] rpm [4];
    logic signed [23:0] spd [4];
    logic [14:0] lim [4];
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    int send_idle, recv_stall, hold_off, quiet_cycles;
    bit hold_req;
    alloc_scoreboard sb;

    mecanum_wheel_power_allocator_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(out_stall),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_yaw_rate(yaw),
        .i_rpm_front_left(rpm[0]), .i_rpm_front_right(rpm[1]),
        .i_rpm_rear_right(rpm[2]), .i_rpm_rear_left(rpm[3]),
        .o_valid(out_valid), .i_stall(in_stall),
        .o_speed_front_left(spd[0]), .o_speed_front_right(spd[1]),
        .o_speed_rear_right(spd[2]), .o_speed_rear_left(spd[3]),
        .o_limit_front_left(lim[0]), .o_limit_front_right(lim[1]),
        .o_limit_rear_right(lim[2]), .o_limit_rear_left(lim[3]),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !out_stall) sb.note_command(vel_x, vel_y, yaw, rpm);
        if (rst_n && out_valid && !in_stall) sb.check_result(spd, lim);
        if (rst_n && ((in_valid && !out_stall) || (out_valid && !in_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > 5000) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_req) begin
            hold_off = 300;
            hold_req = 0;
        end
        if (hold_off > 0) begin
            hold_off--;
            in_stall <= 1;
        end else begin
            in_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send_command(logic [15:0] x, y, w, r0, r1, r2, r3);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        vel_x <= x; vel_y <= y; yaw <= w;
        rpm[0] <= r0; rpm[1] <= r1; rpm[2] <= r2; rpm[3] <= r3;
        @(posedge clk);
        while (out_stall) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(20)) - 16'd10;
            3: return 16'($urandom_range(4000)) - 16'd2000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_command(rand_field(), rand_field(), rand_field(), 0, 0, 0, 0);
            else
                send_command(rand_field(), rand_field(), rand_field(), rand_field(),
                             rand_field(), rand_field(), rand_field());
        end
    endtask

    initial begin
        sb = new();
        rst_n = 0; in_valid = 0; in_stall = 0; cfg_valid = 0; cfg_index = CFG_POWER;
        cfg_data = 0; vel_x = 0; vel_y = 0; yaw = 0; hold_off = 0; hold_req = 0;
        quiet_cycles = 0; send_idle = 0; recv_stall = 0;
        for (int i = 0; i < 4; i++) rpm[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_command(0, 0, 0, 0, 0, 0, 0);
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_command(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_command(16'h7FFF, 16'h8000, 16'h0000, 1, 16'hFFFF, 0, 100);
        send_command(0, 0, 16'h7FFF, 0, 1, 16'hFFFF, 0);
        send_command(1000, 0, 0, 1, 1, 1, 1);
        send_command(0, 16'hFC18, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_INV_RADIUS, 16'hFFFF);
        write_reg(CFG_POWER, 10'd1023);
        write_reg(CFG_HALF_FRAME, 11'd2047);
        write_reg(CFG_CLAMP, 15'h7FFF);
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1, 1, 1);
        send_command(16'h8000, 16'h7FFF, 16'h8000, 0, 0, 16'h8000, 16'h7FFF);
        send_command(5, 3, 16'hFFFF, 1, 2, 3, 4);
        drain();
        write_reg(CFG_INV_RADIUS, 0);
        write_reg(CFG_POWER, 0);
        write_reg(CFG_HALF_FRAME, 0);
        write_reg(CFG_CLAMP, 0);
        send_command(100, 200, 300, 0, 10, 20, 30);
        send_command(16'h8000, 16'h7FFF, 16'h7FFF, 7, 0, 7, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_POWER, (ph == 1) ? 16'd1023 : 16'($urandom_range(1023)));
            write_reg(CFG_HALF_FRAME, (ph == 2) ? 16'd0 : 16'($urandom_range(2047)));
            write_reg(CFG_INV_RADIUS, (ph == 3) ? 16'd1 : 16'($urandom_range(65535)));
            write_reg(CFG_CLAMP, (ph == 4) ? 16'd32767 : 16'($urandom_range(32767)));
            send_idle = 0; recv_stall = 0;
            random_phase(40);
            send_idle = 69; recv_stall = 0;
            random_phase(40);
            send_idle = 0; recv_stall = 69;
            if (ph == 0) hold_req = 1;
            random_phase(40);
            send_idle = 6; recv_stall = 6;
            random_phase(50);
            send_idle = 0; recv_stall = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/mwpa_pkg.sv
rtl/core/mwpa_div.sv
rtl/core/mwpa_speed.sv
rtl/core/mwpa_limit.sv
rtl/core/mecanum_wheel_power_allocator_core.sv
test/tb_top.sv
